@@ rtl/pts_pkg.sv @@
package pts_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int MAX_FIRE      = 16;
   localparam int FIRE_W        = $clog2(MAX_FIRE);
   localparam logic [9:0] TPS_RESET = 10'd10;

   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_DEL  = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [1:0] RES_ADDED = 2'd0;
   localparam logic [1:0] RES_FULL  = 2'd1;
   localparam logic [1:0] RES_FIRED = 2'd2;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_DEL,
      MODE_PEND,
      MODE_MIN
   } mode_type;

   typedef struct packed {
      logic     capture;
      logic     tick_inc;
      logic     scan_start;
      mode_type mode;
      logic     do_add;
      logic     do_fire;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic scan_done;
      logic found;
      logic last_fire;
   } sts_type;

endpackage

@@ rtl/pts_ctrl.sv @@
module pts_ctrl
   import pts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_kind,
   output logic       req_stall,
   input  sts_type    sts,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_DEL,
      S_PEND,
      S_MIN,
      S_FIRE
   } state_type;

   state_type state_ff;
   logic      scan_start_ff;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_start_ff <= 1'b0;
      end else begin
         scan_start_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  unique case (req_kind)
                     KIND_ADD: state_ff <= S_ADD;
                     KIND_DEL: begin
                        state_ff      <= S_DEL;
                        scan_start_ff <= 1'b1;
                     end
                     KIND_TICK: begin
                        state_ff      <= S_PEND;
                        scan_start_ff <= 1'b1;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_ADD: begin
               if (sts.out_free) state_ff <= S_IDLE;
            end
            S_DEL: begin
               if (sts.scan_done) state_ff <= S_IDLE;
            end
            S_PEND: begin
               if (sts.scan_done) begin
                  state_ff      <= S_MIN;
                  scan_start_ff <= 1'b1;
               end
            end
            S_MIN: begin
               if (sts.scan_done) state_ff <= sts.found ? S_FIRE : S_IDLE;
            end
            S_FIRE: begin
               if (sts.out_free) begin
                  if (sts.last_fire) begin
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff      <= S_MIN;
                     scan_start_ff <= 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.capture    = accept;
      cmd.tick_inc   = accept && (req_kind == KIND_TICK);
      cmd.scan_start = scan_start_ff;
      cmd.do_add     = (state_ff == S_ADD) && sts.out_free;
      cmd.do_fire    = (state_ff == S_FIRE) && sts.out_free;
      unique case (state_ff)
         S_DEL:   cmd.mode = MODE_DEL;
         S_PEND:  cmd.mode = MODE_PEND;
         S_MIN:   cmd.mode = MODE_MIN;
         default: cmd.mode = MODE_IDLE;
      endcase
   end

endmodule

@@ rtl/pts_dpath.sv @@
module pts_dpath
   import pts_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic        [15:0] req_start_seconds,
   input  logic        [15:0] req_interval_seconds,
   input  logic        [31:0] req_owner_id,
   input  logic signed [31:0] req_user_word,
   input  logic        [31:0] req_target_id,
   input  logic               csr_wr_en,
   input  logic        [9:0]  csr_wr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [1:0]  rsp_result_kind,
   output logic        [31:0] rsp_timer_id,
   output logic        [31:0] rsp_fired_owner,
   output logic signed [31:0] rsp_fired_word,
   output logic               rsp_last
);

   localparam int IDX_W = $clog2(SLOTS);

   // Timer table storage.
   logic [31:0] mem_deadline [SLOTS];
   logic [31:0] mem_reload   [SLOTS];
   logic [31:0] mem_id       [SLOTS];
   logic [31:0] mem_owner    [SLOTS];
   logic [31:0] mem_word     [SLOTS];

   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] pending_ff;
   logic [9:0]       tps_ff;
   logic [9:0]       tps_eff;
   logic [31:0]      tick_ff;
   logic [31:0]      idcnt_ff;
   logic [FIRE_W-1:0] fired_ff;

   logic [15:0] start_ff;
   logic [15:0] ival_ff;
   logic [31:0] owner_ff;
   logic [31:0] word_ff;
   logic [31:0] target_ff;

   logic [IDX_W-1:0] cnt_ff;
   logic             issuing_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_vld_ff;
   logic [31:0]      rd_deadline_ff;
   logic [31:0]      rd_reload_ff;
   logic [31:0]      rd_id_ff;
   logic [31:0]      rd_owner_ff;
   logic [31:0]      rd_word_ff;

   logic             have_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [31:0]      best_deadline_ff;
   logic [31:0]      best_reload_ff;
   logic [31:0]      best_id_ff;
   logic [31:0]      best_owner_ff;
   logic [31:0]      best_word_ff;

   logic             out_vld_ff;
   logic [1:0]       out_kind_ff;
   logic [31:0]      out_id_ff;
   logic [31:0]      out_owner_ff;
   logic [31:0]      out_word_ff;
   logic             out_last_ff;

   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   logic [25:0]      start_prod;
   logic [25:0]      ival_prod;
   logic             take;
   logic             out_free;
   logic [SLOTS-1:0] best_mask;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign tps_eff    = (tps_ff == 10'd0) ? 10'd1 : tps_ff;
   assign start_prod = {10'b0, start_ff} * {16'b0, tps_eff};
   assign ival_prod  = {10'b0, ival_ff} * {16'b0, tps_eff};

   assign take = rd_vld_ff && pending_ff[rd_idx_ff] &&
                 (!have_ff || (rd_deadline_ff < best_deadline_ff) ||
                  ((rd_deadline_ff == best_deadline_ff) && (rd_id_ff < best_id_ff)));

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign best_mask = {{(SLOTS-1){1'b0}}, 1'b1} << best_idx_ff;

   assign sts.out_free  = out_free;
   assign sts.scan_done = rd_vld_ff && (rd_idx_ff == IDX_W'(SLOTS - 1));
   assign sts.found     = have_ff || ((cmd.mode == MODE_MIN) && take);
   assign sts.last_fire = (fired_ff == FIRE_W'(MAX_FIRE - 1)) ||
                          ((pending_ff & ~best_mask) == '0);

   // Input capture, configuration and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff   <= TPS_RESET;
         tick_ff  <= '0;
         idcnt_ff <= '0;
         fired_ff <= '0;
      end else begin
         if (csr_wr_en) tps_ff <= csr_wr_data;
         if (cmd.tick_inc) begin
            tick_ff  <= tick_ff + 32'd1;
            fired_ff <= '0;
         end
         if (cmd.do_add && free_found) idcnt_ff <= idcnt_ff + 32'd1;
         if (cmd.do_fire) fired_ff <= fired_ff + FIRE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         start_ff  <= req_start_seconds;
         ival_ff   <= req_interval_seconds;
         owner_ff  <= req_owner_id;
         word_ff   <= req_user_word;
         target_ff <= req_target_id;
      end
   end

   // Scan sequencer: one table row read per cycle, data registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         cnt_ff     <= '0;
         rd_idx_ff  <= '0;
      end else begin
         rd_vld_ff <= issuing_ff;
         rd_idx_ff <= cnt_ff;
         if (cmd.scan_start) begin
            issuing_ff <= 1'b1;
            cnt_ff     <= '0;
         end else if (issuing_ff) begin
            cnt_ff <= cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'(SLOTS - 1)) issuing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issuing_ff) begin
         rd_deadline_ff <= mem_deadline[cnt_ff];
         rd_reload_ff   <= mem_reload[cnt_ff];
         rd_id_ff       <= mem_id[cnt_ff];
         rd_owner_ff    <= mem_owner[cnt_ff];
         rd_word_ff     <= mem_word[cnt_ff];
      end
      if (cmd.do_add && free_found) begin
         mem_deadline[free_idx] <= tick_ff + 32'd1 + {6'b0, start_prod};
         mem_reload[free_idx]   <= {6'b0, ival_prod};
         mem_id[free_idx]       <= idcnt_ff + 32'd1;
         mem_owner[free_idx]    <= owner_ff;
         mem_word[free_idx]     <= word_ff;
      end else if (cmd.do_fire && (best_reload_ff != 32'd0)) begin
         mem_deadline[best_idx_ff] <= best_deadline_ff + best_reload_ff;
      end
   end

   // Valid and pending bits, and the best-found flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         pending_ff <= '0;
         have_ff    <= 1'b0;
      end else begin
         if (cmd.do_add && free_found) valid_ff[free_idx] <= 1'b1;
         if (rd_vld_ff && (cmd.mode == MODE_DEL) && valid_ff[rd_idx_ff] &&
             (rd_id_ff == target_ff)) begin
            valid_ff[rd_idx_ff] <= 1'b0;
         end
         if (rd_vld_ff && (cmd.mode == MODE_PEND)) begin
            pending_ff[rd_idx_ff] <= valid_ff[rd_idx_ff] && (tick_ff >= rd_deadline_ff);
         end
         if (cmd.scan_start) have_ff <= 1'b0;
         else if ((cmd.mode == MODE_MIN) && take) have_ff <= 1'b1;
         if (cmd.do_fire) begin
            pending_ff[best_idx_ff] <= 1'b0;
            if (best_reload_ff == 32'd0) valid_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.mode == MODE_MIN) && take) begin
         best_idx_ff      <= rd_idx_ff;
         best_deadline_ff <= rd_deadline_ff;
         best_reload_ff   <= rd_reload_ff;
         best_id_ff       <= rd_id_ff;
         best_owner_ff    <= rd_owner_ff;
         best_word_ff     <= rd_word_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.do_add || cmd.do_fire) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_add) begin
         out_kind_ff  <= free_found ? RES_ADDED : RES_FULL;
         out_id_ff    <= free_found ? (idcnt_ff + 32'd1) : 32'd0;
         out_owner_ff <= '0;
         out_word_ff  <= '0;
         out_last_ff  <= 1'b1;
      end else if (cmd.do_fire) begin
         out_kind_ff  <= RES_FIRED;
         out_id_ff    <= best_id_ff;
         out_owner_ff <= best_owner_ff;
         out_word_ff  <= best_word_ff;
         out_last_ff  <= sts.last_fire;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_timer_id    = out_id_ff;
   assign rsp_fired_owner = out_owner_ff;
   assign rsp_fired_word  = out_word_ff;
   assign rsp_last        = out_last_ff;

endmodule

@@ rtl/periodic_timer_scheduler.sv @@
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  kind, start, interval, owner, word, target
// rsp_      out        rsp_valid/rsp_stall  result kind, timer id, owner, word, last
// csr_      in         csr_wr_en            ticks per second (10 bits)
//
// An add needs no table scan; it waits only for the result register to be free.
// A delete runs one table scan, reading one row per cycle.
// A tick runs one scan for the due timers, then one minimum scan for
// each timer that fires, since every firing rescans the table for the minimum.
// A tick on which no timer is due still runs one minimum scan.
// Reset is synchronous and clears the control state, the counters and the valid and
// pending bits, and sets ticks per second to 10; the table rows are left as they are.
// A stalled result holds the block; the next item is taken once the current one
// is done, for an add or a firing tick once its last beat is in the result register.
module periodic_timer_scheduler
   import pts_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic        [1:0]  req_kind,
   input  logic        [15:0] req_start_seconds,
   input  logic        [15:0] req_interval_seconds,
   input  logic        [31:0] req_owner_id,
   input  logic signed [31:0] req_user_word,
   input  logic        [31:0] req_target_id,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [1:0]  rsp_result_kind,
   output logic        [31:0] rsp_timer_id,
   output logic        [31:0] rsp_fired_owner,
   output logic signed [31:0] rsp_fired_word,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic        [9:0]  csr_wr_data
);

   // The controller sequences scans and firings; the datapath owns the table.
   cmd_type cmd;
   sts_type sts;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pts_dpath #(.SLOTS(SLOTS)) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_start_seconds    (req_start_seconds),
      .req_interval_seconds (req_interval_seconds),
      .req_owner_id         (req_owner_id),
      .req_user_word        (req_user_word),
      .req_target_id        (req_target_id),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_timer_id         (rsp_timer_id),
      .rsp_fired_owner      (rsp_fired_owner),
      .rsp_fired_word       (rsp_fired_word),
      .rsp_last             (rsp_last)
   );

endmodule

@@ rtl/pts_checker.sv @@
module pts_checker
   import pts_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic        [1:0]  rsp_result_kind,
   input logic        [31:0] rsp_timer_id,
   input logic        [31:0] rsp_fired_owner,
   input logic signed [31:0] rsp_fired_word,
   input logic               rsp_last
);

   // A stalled result beat holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_timer_id))
      else $error("stalled result changed");

   // Add answers are always a single beat.
   a_add_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind != RES_FIRED) |-> rsp_last)
      else $error("add answer without last");

   a_full_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == RES_FULL) |-> (rsp_timer_id == 32'd0))
      else $error("reject with nonzero id");

   a_add_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind != RES_FIRED) |->
      (rsp_fired_owner == 32'd0) && (rsp_fired_word == 32'sd0))
      else $error("add answer with timer data");

endmodule

bind periodic_timer_scheduler pts_checker u_pts_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_timer_id    (rsp_timer_id),
   .rsp_fired_owner (rsp_fired_owner),
   .rsp_fired_word  (rsp_fired_word),
   .rsp_last        (rsp_last)
);
